FILE: sv/lspe_pkg.sv
// Package for the LED strip pulse encoder: command and register codes,
// result layout and reset values of the timing registers.
// No dependencies.
package lspe_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned WORD_BITS = 24;
  localparam int unsigned BITS_W = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_HIGH  = 3'd0,
    CFG_ONE_LOW   = 3'd1,
    CFG_ZERO_HIGH = 3'd2,
    CFG_ZERO_LOW  = 3'd3,
    CFG_LATCH     = 3'd4
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] RST_ONE_HIGH  = 16'd40;
  localparam logic [CFG_DATA_W-1:0] RST_ONE_LOW   = 16'd10;
  localparam logic [CFG_DATA_W-1:0] RST_ZERO_HIGH = 16'd10;
  localparam logic [CFG_DATA_W-1:0] RST_ZERO_LOW  = 16'd40;
  localparam logic [CFG_DATA_W-1:0] RST_LATCH     = 16'd1000;

  // line_level sits in the lowest bit
  typedef struct packed {
    logic frame_done;
    logic busy_res;
    logic refused;
    logic taken;
    logic line_level;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

endpackage

FILE: sv/lspe_core.sv
// Waveform state and per-tick step logic of the LED strip pulse encoder.
// Depends on lspe_pkg.
module lspe_core #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [lspe_pkg::CMD_W-1:0]          cmd,
  input  logic [lspe_pkg::COLOR_W-1:0]        red,
  input  logic [lspe_pkg::COLOR_W-1:0]        green,
  input  logic [lspe_pkg::COLOR_W-1:0]        blue,
  input  logic [TIME_BITS-1:0]                one_high,
  input  logic [TIME_BITS-1:0]                one_low,
  input  logic [TIME_BITS-1:0]                zero_high,
  input  logic [TIME_BITS-1:0]                zero_low,
  input  logic [TIME_BITS-1:0]                latch_len,
  output lspe_pkg::result_t                   res
);

  localparam logic [TIME_BITS-1:0] T_ONE = TIME_BITS'(1);

  logic [lspe_pkg::WORD_BITS-1:0] shift_word_r, shift_word_nxt;
  logic [lspe_pkg::WORD_BITS-1:0] held_word_r, held_word_nxt;
  logic [lspe_pkg::BITS_W-1:0]    bits_left_r, bits_left_nxt;
  logic                           in_low_r, in_low_nxt;
  logic [TIME_BITS-1:0]           phase_r, phase_nxt;
  logic                           held_valid_r, held_valid_nxt;
  logic                           end_pend_r, end_pend_nxt;
  logic [TIME_BITS-1:0]           latch_cnt_r, latch_cnt_nxt;

  // zero-length settings count as one tick
  logic [TIME_BITS-1:0] oh_t, ol_t, zh_t, zl_t, lat_t;

  assign oh_t  = (one_high  == '0) ? T_ONE : one_high;
  assign ol_t  = (one_low   == '0) ? T_ONE : one_low;
  assign zh_t  = (zero_high == '0) ? T_ONE : zero_high;
  assign zl_t  = (zero_low  == '0) ? T_ONE : zero_low;
  assign lat_t = (latch_len == '0) ? T_ONE : latch_len;

  always_comb begin
    logic                           is_req;
    logic                           slot_full;
    logic [lspe_pkg::WORD_BITS-1:0] sh_next;
    logic [lspe_pkg::BITS_W-1:0]    bl_next;
    logic [TIME_BITS-1:0]           ph_dec;

    shift_word_nxt = shift_word_r;
    held_word_nxt  = held_word_r;
    bits_left_nxt  = bits_left_r;
    in_low_nxt     = in_low_r;
    phase_nxt      = phase_r;
    held_valid_nxt = held_valid_r;
    end_pend_nxt   = end_pend_r;
    latch_cnt_nxt  = latch_cnt_r;
    res            = '0;
    sh_next        = '0;
    bl_next        = '0;
    ph_dec         = '0;

    // command is judged against the slot before this tick
    slot_full = held_valid_r | end_pend_r;
    case (cmd) inside
      lspe_pkg::CMD_PIXEL,
      lspe_pkg::CMD_END: is_req = 1'b1;
      default:           is_req = 1'b0;
    endcase
    res.refused = is_req & slot_full;
    res.taken   = is_req & ~slot_full;
    if (res.taken) begin
      if (cmd == lspe_pkg::CMD_PIXEL) begin
        held_word_nxt  = {blue, red, green};
        held_valid_nxt = 1'b1;
      end else begin
        end_pend_nxt = 1'b1;
      end
    end

    // idle line loads from the slot
    if (bits_left_r == '0 && latch_cnt_r == '0) begin
      if (held_valid_nxt) begin
        shift_word_nxt = held_word_nxt;
        bits_left_nxt  = lspe_pkg::BITS_W'(lspe_pkg::WORD_BITS);
        in_low_nxt     = 1'b0;
        phase_nxt      = held_word_nxt[lspe_pkg::WORD_BITS-1] ? oh_t : zh_t;
        held_valid_nxt = 1'b0;
      end else if (end_pend_nxt) begin
        latch_cnt_nxt = lat_t;
        end_pend_nxt  = 1'b0;
      end
    end

    // one tick of the waveform
    if (bits_left_nxt != '0) begin
      res.line_level = ~in_low_nxt;
      ph_dec = (phase_nxt != '0) ? phase_nxt - T_ONE : phase_nxt;
      phase_nxt = ph_dec;
      if (ph_dec == '0) begin
        if (!in_low_nxt) begin
          in_low_nxt = 1'b1;
          phase_nxt  = shift_word_nxt[lspe_pkg::WORD_BITS-1] ? ol_t : zl_t;
        end else begin
          sh_next        = {shift_word_nxt[lspe_pkg::WORD_BITS-2:0], 1'b0};
          bl_next        = bits_left_nxt - lspe_pkg::BITS_W'(1);
          shift_word_nxt = sh_next;
          bits_left_nxt  = bl_next;
          in_low_nxt     = 1'b0;
          if (bl_next != '0) begin
            phase_nxt = sh_next[lspe_pkg::WORD_BITS-1] ? oh_t : zh_t;
          end else begin
            phase_nxt = '0;
          end
        end
      end
    end else if (latch_cnt_nxt != '0) begin
      latch_cnt_nxt  = latch_cnt_nxt - T_ONE;
      res.frame_done = (latch_cnt_nxt == '0);
    end

    res.busy_res = (bits_left_nxt != '0) | held_valid_nxt | end_pend_nxt |
                   (latch_cnt_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_word_r <= '0;
      held_word_r  <= '0;
      bits_left_r  <= '0;
      in_low_r     <= 1'b0;
      phase_r      <= '0;
      held_valid_r <= 1'b0;
      end_pend_r   <= 1'b0;
      latch_cnt_r  <= '0;
    end else if (step) begin
      shift_word_r <= shift_word_nxt;
      held_word_r  <= held_word_nxt;
      bits_left_r  <= bits_left_nxt;
      in_low_r     <= in_low_nxt;
      phase_r      <= phase_nxt;
      held_valid_r <= held_valid_nxt;
      end_pend_r   <= end_pend_nxt;
      latch_cnt_r  <= latch_cnt_nxt;
    end
  end

endmodule

FILE: sv/led_strip_pulse_encoder.sv
// Top level of the LED strip pulse encoder: timing registers, output
// register with skid stage, and checks. Depends on lspe_pkg and lspe_core.
//
//  channel   direction  payload                                   transaction
//  in_*      sink       tuser: command; tdata: red, green, blue    one tick
//  out_*     source     tdata: line_level .. busy_res; tlast: frame_done
//  cfg_*     sink       cfg_index, cfg_data                       one write
//
// One input transaction per clock while in_tready is high. Its result goes
// to the output register, or to the skid stage if the output is stalled;
// that stage keeps one result, and in_tready drops only while it is occupied.
// The step logic (slot check, load, one countdown) is the only stage.
// Synchronous reset clears the waveform state and restores register defaults.
module led_strip_pulse_encoder #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lspe_pkg::IN_DATA_W-1:0]      in_tdata,   // red, green, blue
  input  logic [lspe_pkg::CMD_W-1:0]          in_tuser,   // command
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // line_level, taken, refused, busy_res, zero pad
  output logic [lspe_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,  // frame_done
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lspe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lspe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [TIME_BITS-1:0] one_high_r, one_low_r, zero_high_r, zero_low_r, latch_r;
  logic [TIME_BITS-1:0] cfg_val;

  lspe_pkg::result_t res;
  lspe_pkg::result_t out_data_r, out_data_nxt;
  lspe_pkg::result_t skid_data_r, skid_data_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic              in_acc, out_acc;

  assign cfg_ready = 1'b1;
  assign cfg_val   = TIME_BITS'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_high_r  <= TIME_BITS'(lspe_pkg::RST_ONE_HIGH);
      one_low_r   <= TIME_BITS'(lspe_pkg::RST_ONE_LOW);
      zero_high_r <= TIME_BITS'(lspe_pkg::RST_ZERO_HIGH);
      zero_low_r  <= TIME_BITS'(lspe_pkg::RST_ZERO_LOW);
      latch_r     <= TIME_BITS'(lspe_pkg::RST_LATCH);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lspe_pkg::CFG_ONE_HIGH:  one_high_r  <= cfg_val;
        lspe_pkg::CFG_ONE_LOW:   one_low_r   <= cfg_val;
        lspe_pkg::CFG_ZERO_HIGH: zero_high_r <= cfg_val;
        lspe_pkg::CFG_ZERO_LOW:  zero_low_r  <= cfg_val;
        lspe_pkg::CFG_LATCH:     latch_r     <= cfg_val;
        default: ;
      endcase
    end
  end

  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_tvalid & out_tready;

  lspe_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .cmd       (in_tuser),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .one_high  (one_high_r),
    .one_low   (one_low_r),
    .zero_high (zero_high_r),
    .zero_low  (zero_low_r),
    .latch_len (latch_r),
    .res       (res)
  );

  always_comb begin
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_valid_nxt = skid_valid_r;
    if (out_acc || !out_valid_r) begin
      // skid drains first; no input is taken while it holds a result
      out_valid_nxt  = skid_valid_r | in_acc;
      out_data_nxt   = skid_valid_r ? skid_data_r : res;
      skid_valid_nxt = 1'b0;
    end else if (in_acc) begin
      skid_data_nxt  = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lspe_pkg::OUT_DATA_W - lspe_pkg::RES_W + 1){1'b0}},
                       out_data_r.busy_res, out_data_r.refused,
                       out_data_r.taken, out_data_r.line_level};
  assign out_tlast  = out_data_r.frame_done;

  // skid stage only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage valid with empty output register");

  a_take_or_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !(res.taken && res.refused))
    else $error("command both taken and refused");

  // a one-tick reset pulse may start and end on the tick its request is taken
  a_taken_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.taken) |-> (res.busy_res || res.frame_done))
    else $error("accepted command left block idle");

  a_done_line_low: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.frame_done) |-> !res.line_level)
    else $error("frame done while line high");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

endmodule

FILE: test/led_strip_pulse_encoder_tb.sv
// Testbench for led_strip_pulse_encoder: drives line ticks, pixel offers and
// end-of-frame requests and checks every per-tick result against a predictor.
// Depends on lspe_pkg and the led_strip_pulse_encoder RTL.
`timescale 1ns / 100ps

module led_strip_pulse_encoder_tb;

  localparam logic [lspe_pkg::CMD_W-1:0] CMD_RSVD = 2'd3;  // behaves as a plain tick

  // Tracks the line waveform state; each accepted tick queues its result.
  class line_tick_scoreboard;
    logic [lspe_pkg::CFG_DATA_W-1:0] one_hi, one_lo, zero_hi, zero_lo, latch_len;
    logic [lspe_pkg::WORD_BITS-1:0]  shifter, slot_word;
    logic [lspe_pkg::BITS_W-1:0]     bits_rem;
    logic [lspe_pkg::CFG_DATA_W-1:0] phase_cnt, latch_cnt;
    bit                              low_half, slot_pixel, slot_end;
    lspe_pkg::result_t               pending_results[$];
    int                              errors;

    function new();
      one_hi     = lspe_pkg::RST_ONE_HIGH;
      one_lo     = lspe_pkg::RST_ONE_LOW;
      zero_hi    = lspe_pkg::RST_ZERO_HIGH;
      zero_lo    = lspe_pkg::RST_ZERO_LOW;
      latch_len  = lspe_pkg::RST_LATCH;
      shifter    = '0;
      slot_word  = '0;
      bits_rem   = '0;
      phase_cnt  = '0;
      latch_cnt  = '0;
      low_half   = 1'b0;
      slot_pixel = 1'b0;
      slot_end   = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(lspe_pkg::cfg_idx_t idx, logic [lspe_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        lspe_pkg::CFG_ONE_HIGH:  one_hi = v;
        lspe_pkg::CFG_ONE_LOW:   one_lo = v;
        lspe_pkg::CFG_ZERO_HIGH: zero_hi = v;
        lspe_pkg::CFG_ZERO_LOW:  zero_lo = v;
        lspe_pkg::CFG_LATCH:     latch_len = v;
        default: ;
      endcase
    endfunction

    // a programmed zero still lasts one tick
    function logic [lspe_pkg::CFG_DATA_W-1:0] floor_one(logic [lspe_pkg::CFG_DATA_W-1:0] v);
      return (v == '0) ? 16'd1 : v;
    endfunction

    function logic [lspe_pkg::CFG_DATA_W-1:0] high_len();
      return floor_one(shifter[lspe_pkg::WORD_BITS-1] ? one_hi : zero_hi);
    endfunction

    function logic [lspe_pkg::CFG_DATA_W-1:0] low_len();
      return floor_one(shifter[lspe_pkg::WORD_BITS-1] ? one_lo : zero_lo);
    endfunction

    function bit slot_full();
      return slot_pixel || slot_end;
    endfunction

    function bit line_active();
      return bits_rem != '0 || slot_full() || latch_cnt != '0;
    endfunction

    function void note_tick(logic [lspe_pkg::CMD_W-1:0] cmd,
                            logic [lspe_pkg::COLOR_W-1:0] red,
                            logic [lspe_pkg::COLOR_W-1:0] green,
                            logic [lspe_pkg::COLOR_W-1:0] blue);
      lspe_pkg::result_t res;
      res = '0;
      // command is judged against the slot as it was before this tick
      if (cmd == lspe_pkg::CMD_PIXEL || cmd == lspe_pkg::CMD_END) begin
        if (slot_full()) begin
          res.refused = 1'b1;
        end else if (cmd == lspe_pkg::CMD_PIXEL) begin
          slot_word  = {blue, red, green};
          slot_pixel = 1'b1;
          res.taken  = 1'b1;
        end else begin
          slot_end  = 1'b1;
          res.taken = 1'b1;
        end
      end
      if (bits_rem == '0 && latch_cnt == '0) begin
        if (slot_pixel) begin
          shifter    = slot_word;
          bits_rem   = lspe_pkg::BITS_W'(lspe_pkg::WORD_BITS);
          low_half   = 1'b0;
          phase_cnt  = high_len();
          slot_pixel = 1'b0;
        end else if (slot_end) begin
          latch_cnt = floor_one(latch_len);
          slot_end  = 1'b0;
        end
      end
      if (bits_rem != '0) begin
        res.line_level = !low_half;
        if (phase_cnt != '0) phase_cnt--;
        if (phase_cnt == '0) begin
          if (!low_half) begin
            low_half  = 1'b1;
            phase_cnt = low_len();
          end else begin
            shifter   = shifter << 1;
            bits_rem--;
            low_half  = 1'b0;
            phase_cnt = (bits_rem != '0) ? high_len() : '0;
          end
        end
      end else if (latch_cnt != '0) begin
        latch_cnt--;
        if (latch_cnt == '0) res.frame_done = 1'b1;
      end
      res.busy_res = line_active();
      pending_results.push_back(res);
    endfunction

    function void check_field(string name, logic want, logic got);
      if (got !== want) begin
        $error("%s: expected %0b, got %0b", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [lspe_pkg::OUT_DATA_W-1:0] data, logic last);
      lspe_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: %b %b", data, last);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("line_level", want.line_level, data[0]);
      check_field("taken", want.taken, data[1]);
      check_field("refused", want.refused, data[2]);
      check_field("busy_res", want.busy_res, data[3]);
      check_field("frame_done", want.frame_done, last);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [lspe_pkg::IN_DATA_W-1:0]  in_tdata   = '0;   // red, green, blue
  logic [lspe_pkg::CMD_W-1:0]      in_tuser   = '0;   // command
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lspe_pkg::OUT_DATA_W-1:0] out_tdata;         // line_level .. busy_res, pad
  logic                            out_tlast;         // frame_done
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [lspe_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [lspe_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  line_tick_scoreboard sb = new();

  led_strip_pulse_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200_000;
    $display("led_strip_pulse_encoder_tb: errors");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  function automatic logic [lspe_pkg::COLOR_W-1:0] rand_color();
    return lspe_pkg::COLOR_W'($urandom_range(255));
  endfunction

  function automatic logic [lspe_pkg::CFG_DATA_W-1:0] rand_len(int unsigned max_len);
    return lspe_pkg::CFG_DATA_W'($urandom_range(max_len));
  endfunction

  task automatic push_tick(logic [lspe_pkg::CMD_W-1:0] cmd,
                           logic [lspe_pkg::COLOR_W-1:0] red,
                           logic [lspe_pkg::COLOR_W-1:0] green,
                           logic [lspe_pkg::COLOR_W-1:0] blue);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {blue, green, red};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(cmd, red, green, blue);
  endtask

  task automatic push_plain();
    push_tick(lspe_pkg::CMD_TICK, rand_color(), rand_color(), rand_color());
  endtask

  // tick until bits, the slot and the reset pulse are all gone
  task automatic drain_line();
    while (sb.line_active()) push_plain();
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(lspe_pkg::cfg_idx_t idx, logic [lspe_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [lspe_pkg::CFG_DATA_W-1:0] one_hi,
                           logic [lspe_pkg::CFG_DATA_W-1:0] one_lo,
                           logic [lspe_pkg::CFG_DATA_W-1:0] zero_hi,
                           logic [lspe_pkg::CFG_DATA_W-1:0] zero_lo,
                           logic [lspe_pkg::CFG_DATA_W-1:0] latch_len);
    quiesce();
    write_reg(lspe_pkg::CFG_ONE_HIGH, one_hi);
    write_reg(lspe_pkg::CFG_ONE_LOW, one_lo);
    write_reg(lspe_pkg::CFG_ZERO_HIGH, zero_hi);
    write_reg(lspe_pkg::CFG_ZERO_LOW, zero_lo);
    write_reg(lspe_pkg::CFG_LATCH, latch_len);
  endtask

  // Frames (pixels then an end request) with short bit times, mixed with plain
  // ticks, reserved commands and offers that hit a full slot.
  task automatic run_random(int n);
    int roll;
    logic [lspe_pkg::CMD_W-1:0] cmd;
    configure(rand_len(2), rand_len(2), rand_len(2), rand_len(2), rand_len(4));
    repeat (n) begin
      roll = $urandom_range(99);
      if (!sb.slot_full())
        cmd = (roll < 45) ? lspe_pkg::CMD_PIXEL : (roll < 55) ? lspe_pkg::CMD_END :
              (roll < 93) ? lspe_pkg::CMD_TICK : CMD_RSVD;
      else
        cmd = (roll < 5) ? lspe_pkg::CMD_PIXEL : (roll < 8) ? lspe_pkg::CMD_END :
              (roll < 12) ? CMD_RSVD : lspe_pkg::CMD_TICK;
      push_tick(cmd, rand_color(), rand_color(), rand_color());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    tx_idle_pct  = 28;
    rx_stall_pct = 72;
    configure(16'd2, 16'd1, 16'd1, 16'd1, 16'd3);
    // idle block starts at once; second pixel waits in the slot; then full
    push_tick(lspe_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_tick(lspe_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    push_tick(lspe_pkg::CMD_PIXEL, 8'hAA, 8'h55, 8'hAA);
    push_tick(lspe_pkg::CMD_END, 8'h00, 8'h00, 8'h00);
    push_tick(CMD_RSVD, 8'h5A, 8'hA5, 8'h3C);
    push_plain();
    drain_line();
    // pixel offered during the reset pulse is held until it ends
    push_tick(lspe_pkg::CMD_END, 8'h00, 8'h00, 8'h00);
    push_tick(lspe_pkg::CMD_PIXEL, 8'h12, 8'h34, 8'h80);
    push_tick(lspe_pkg::CMD_END, 8'h00, 8'h00, 8'h00);
    drain_line();
    push_tick(lspe_pkg::CMD_PIXEL, 8'h01, 8'h7F, 8'h80);
    push_tick(lspe_pkg::CMD_END, 8'hFF, 8'hFF, 8'hFF);
    push_tick(lspe_pkg::CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);
    drain_line();
    // all durations programmed as zero
    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_tick(lspe_pkg::CMD_PIXEL, 8'h0F, 8'h55, 8'hF0);
    push_tick(lspe_pkg::CMD_END, 8'h00, 8'h00, 8'h00);
    push_tick(lspe_pkg::CMD_END, 8'h00, 8'h00, 8'h00);
    drain_line();
    run_random(20);
    run_random(20);

    tx_idle_pct  = 72;
    rx_stall_pct = 28;
    run_random(20);
    run_random(20);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_random(20);
    run_random(20);
    drain_line();
    // longest bit times: only their start is exercised
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_tick(lspe_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    push_tick(lspe_pkg::CMD_PIXEL, 8'hC3, 8'h3C, 8'h99);
    repeat (20) push_plain();
    quiesce();
    repeat (10) @(posedge clk);

    if (sb.errors == 0)
      $display("led_strip_pulse_encoder_tb: clean");
    else
      $display("led_strip_pulse_encoder_tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
sv/lspe_pkg.sv
sv/lspe_core.sv
sv/led_strip_pulse_encoder.sv
test/led_strip_pulse_encoder_tb.sv
